// ===== sv/telnet_option_parser_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Telnet option parser assertion macros
// Shared assertion forms for the telnet option parser checkers.
// ---------------------------------------------------------------------------
`ifndef TELNET_OPTION_PARSER_UNIT_DEFINES_SVH
`define TELNET_OPTION_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TNOPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TNOPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tnopt_pkg.sv =====
// ---------------------------------------------------------------------------
// Telnet option parser package
// Protocol codes, reply constants, job and result types and the reply
// sequencing function shared by the parser modules.
// ---------------------------------------------------------------------------
package tnopt_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_NOP  = 8'd241;
  localparam logic [7:0] B_GA   = 8'd249;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;

  localparam logic [7:0] COLS_WIDE   = 8'd80;
  localparam logic [7:0] COLS_NARROW = 8'd40;
  localparam logic [7:0] ROWS_ANSI   = 8'd25;
  localparam logic [7:0] ROWS_PLAIN  = 8'd24;
  localparam logic [7:0] BYTE_ZERO   = 8'd0;
  localparam logic [7:0] BYTE_ESC_FF = 8'hFF;

  localparam logic [7:0] ANSI_NAME [4] = '{8'h41, 8'h4E, 8'h53, 8'h49};
  localparam logic [7:0] VT_NAME   [4] = '{8'h56, 8'h54, 8'h35, 8'h32};

  localparam logic [1:0] CNT_FULL = 2'd3;

  localparam int IDX_W = 4;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] CFG_ANSI_MODE     = 2'd0;
  localparam logic [1:0] CFG_NARROW_SCREEN = 2'd1;
  localparam logic [1:0] CFG_AUTO_DOWNLOAD = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_SUB,
    PH_SUBIAC
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DISPLAY,
    KIND_TX,
    KIND_EVENT
  } out_kind_t;

  typedef enum logic [1:0] {
    JOB_DISP,
    JOB_TX3,
    JOB_NAWS,
    JOB_TTYPE
  } job_kind_t;

  typedef struct packed {
    logic ansi_mode;
    logic narrow_screen;
    logic auto_download;
  } cfg_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       event_req;
    logic [7:0] cols;
    logic [7:0] rows;
    logic       ansi;
    logic       echo;
  } job_t;

  typedef struct packed {
    out_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } item_t;

  function automatic item_t gen_item(job_t j, logic [IDX_W-1:0] idx);
    item_t      it;
    logic [7:0] name_b;
    it.kind = KIND_TX;
    it.data = BYTE_ZERO;
    it.last = 1'b0;
    name_b  = j.ansi ? ANSI_NAME[idx[1:0]] : VT_NAME[idx[1:0]];
    case (j.kind)
      JOB_DISP: begin
        it.kind = KIND_DISPLAY;
        it.data = j.b0;
        it.last = 1'b1;
      end
      JOB_TX3: begin
        case (idx)
          4'd0: it.data = B_IAC;
          4'd1: it.data = j.b0;
          4'd2: begin
            it.data = j.b1;
            it.last = !j.event_req;
          end
          default: begin
            it.kind = KIND_EVENT;
            it.last = 1'b1;
          end
        endcase
      end
      JOB_NAWS: begin
        case (idx)
          4'd0:    it.data = B_IAC;
          4'd1:    it.data = B_WILL;
          4'd2:    it.data = OPT_NAWS;
          4'd3:    it.data = B_IAC;
          4'd4:    it.data = B_SB;
          4'd5:    it.data = OPT_NAWS;
          4'd6:    it.data = BYTE_ZERO;
          4'd7:    it.data = j.cols;
          4'd8:    it.data = BYTE_ZERO;
          4'd9:    it.data = j.rows;
          4'd10:   it.data = B_IAC;
          default: begin
            it.data = B_SE;
            it.last = 1'b1;
          end
        endcase
      end
      default: begin
        case (idx) inside
          4'd0:          it.data = B_IAC;
          4'd1:          it.data = B_SB;
          4'd2:          it.data = OPT_TTYPE;
          4'd3:          it.data = BYTE_ZERO;
          [4'd4:4'd7]:   it.data = name_b;
          4'd8:          it.data = B_IAC;
          default: begin
            it.data = B_SE;
            it.last = 1'b1;
          end
        endcase
      end
    endcase
    return it;
  endfunction

endpackage

// ===== sv/telnet_option_parser_unit.sv =====
// ---------------------------------------------------------------------------
// Telnet option parser unit
// Receive-side telnet command parser with option negotiation replies.
// ---------------------------------------------------------------------------
// A received byte is taken whenever the reply queue has room, so bytes
// may arrive back to back. Results leave one per cycle, while out_stall is
// low, from a single output register: a display byte gives one result, a
// three-byte answer three (four with the file-transfer event), a terminal
// type reply ten results and a window size reply twelve. The queue of
// QUEUE_DEPTH reply jobs absorbs bursts; once it fills, in_stall rises until
// the sequencer frees an entry. Configuration writes are always accepted.
module telnet_option_parser_unit
  import tnopt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_enter_seen,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_local_echo,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_valid;
  job_t q_in, q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANSI_MODE:     cfg_nxt.ansi_mode     = cfg_data;
        CFG_NARROW_SCREEN: cfg_nxt.narrow_screen = cfg_data;
        CFG_AUTO_DOWNLOAD: cfg_nxt.auto_download = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tnopt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_enter_seen (in_enter_seen),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_in)
  );

  tnopt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_job   (q_head),
    .head_valid (q_valid)
  );

  tnopt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_valid),
    .job            (q_head),
    .job_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_local_echo (out_local_echo)
  );

endmodule

// ===== sv/tnopt_front.sv =====
// ---------------------------------------------------------------------------
// Telnet option parser front end
// Accepts received bytes, tracks the command phase and the echo and download
// flags, and turns each byte that needs output into one reply job.
// ---------------------------------------------------------------------------
module tnopt_front
  import tnopt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_enter_seen,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  phase_t     phase_r, phase_nxt;
  logic [1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0] verb_r, verb_nxt, opt_r, opt_nxt, verb_cur, opt_cur;
  logic       echo_r, echo_nxt, armed_r, armed_nxt;
  logic       accept, do_answer, is_cmd1, is_short;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = (cnt_r == CNT_FULL) ? CNT_FULL : cnt_r + 2'd1;
  assign is_cmd1  = (cnt_r == 2'd1);
  assign is_short = (in_rx_byte >= B_NOP) && (in_rx_byte <= B_GA);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == B_IAC) begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          if (is_cmd1 && (in_rx_byte == B_IAC)) begin
            phase_nxt = PH_IDLE;
          end else if (is_cmd1 && is_short) begin
            phase_nxt = PH_IDLE;
          end else if (is_cmd1 && (in_rx_byte == B_SB)) begin
            phase_nxt = PH_SUB;
          end else if (cnt_inc == CNT_FULL) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_SUB: begin
          if (in_rx_byte == B_IAC) begin
            phase_nxt = PH_SUBIAC;
          end
        end
        PH_SUBIAC: begin
          phase_nxt = (in_rx_byte == B_SE) ? PH_IDLE : PH_SUB;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    verb_cur  = verb_r;
    opt_cur   = opt_r;
    verb_nxt  = verb_r;
    opt_nxt   = opt_r;
    cnt_nxt   = cnt_r;
    echo_nxt  = echo_r;
    armed_nxt = armed_r;
    do_answer = 1'b0;
    q_push    = 1'b0;
    q_job.kind      = JOB_DISP;
    q_job.b0        = in_rx_byte;
    q_job.b1        = opt_r;
    q_job.event_req = 1'b0;
    q_job.cols      = cfg.ansi_mode ? COLS_WIDE
                    : (cfg.narrow_screen ? COLS_NARROW : COLS_WIDE);
    q_job.rows      = cfg.ansi_mode ? ROWS_ANSI : ROWS_PLAIN;
    q_job.ansi      = cfg.ansi_mode;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == B_IAC) begin
            cnt_nxt = 2'd1;
          end else begin
            q_push = 1'b1;
          end
        end
        PH_CMD: begin
          if (is_cmd1 && (in_rx_byte == B_IAC)) begin
            q_push   = 1'b1;
            q_job.b0 = BYTE_ESC_FF;
          end else if (is_cmd1 && is_short) begin
            cnt_nxt = cnt_r;
          end else if (is_cmd1 && (in_rx_byte == B_SB)) begin
            verb_nxt = B_SB;
            cnt_nxt  = 2'd2;
          end else begin
            if (is_cmd1) begin
              verb_cur = in_rx_byte;
            end
            if (cnt_r == 2'd2) begin
              opt_cur = in_rx_byte;
            end
            verb_nxt  = verb_cur;
            opt_nxt   = opt_cur;
            cnt_nxt   = cnt_inc;
            do_answer = (cnt_inc == CNT_FULL);
          end
        end
        PH_SUB: begin
          if (cnt_r == 2'd2) begin
            opt_nxt = in_rx_byte;
          end
          cnt_nxt = cnt_inc;
        end
        PH_SUBIAC: begin
          if (in_rx_byte == B_SE) begin
            do_answer = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: cnt_nxt = cnt_r;
      endcase
    end
    if (do_answer) begin
      q_job.b1 = opt_cur;
      unique case (verb_cur)
        B_DO: begin
          q_push = 1'b1;
          if (opt_cur == OPT_NAWS) begin
            q_job.kind = JOB_NAWS;
          end else begin
            q_job.kind = JOB_TX3;
            q_job.b0   = ((opt_cur == OPT_TTYPE) || (opt_cur == OPT_BINARY)) ? B_WILL : B_WONT;
          end
        end
        B_WILL: begin
          q_push     = 1'b1;
          q_job.kind = JOB_TX3;
          q_job.b0   = B_DO;
          if (opt_cur == OPT_ECHO) begin
            echo_nxt = 1'b0;
          end else if (opt_cur == OPT_BINARY) begin
            if (!in_enter_seen) begin
              armed_nxt = 1'b0;
            end else begin
              q_job.event_req = cfg.auto_download && armed_r;
            end
          end
        end
        B_WONT: begin
          q_push     = 1'b1;
          q_job.kind = JOB_TX3;
          q_job.b0   = B_DONT;
          if (opt_cur == OPT_ECHO) begin
            echo_nxt = 1'b1;
          end
        end
        B_DONT: begin
          q_push     = 1'b1;
          q_job.kind = JOB_TX3;
          q_job.b0   = B_WONT;
        end
        B_SB: begin
          q_push     = (opt_cur == OPT_TTYPE);
          q_job.kind = JOB_TTYPE;
        end
        default: q_push = 1'b0;
      endcase
    end
    q_job.echo = echo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 2'd0;
      verb_r  <= BYTE_ZERO;
      opt_r   <= BYTE_ZERO;
      echo_r  <= 1'b0;
      armed_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      verb_r  <= verb_nxt;
      opt_r   <= opt_nxt;
      echo_r  <= echo_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

// ===== sv/tnopt_queue.sv =====
// ---------------------------------------------------------------------------
// Telnet option parser job queue
// Small first-in first-out buffer of reply jobs between the front end and
// the reply sequencer.
// ---------------------------------------------------------------------------
module tnopt_queue
  import tnopt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_MAX);
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/tnopt_back.sv =====
// ---------------------------------------------------------------------------
// Telnet option parser reply sequencer
// Expands the job at the head of the queue into result items, one per
// cycle while out_stall is low, through a registered output stage.
// ---------------------------------------------------------------------------
module tnopt_back
  import tnopt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_local_echo
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  item_t            item, item_r;
  logic             echo_r, load;

  assign item    = gen_item(job, idx_r);
  assign load    = job_valid && (!valid_r || !out_stall);
  assign job_pop = load && item.last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = item.last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
      echo_r <= job.echo;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = item_r.kind;
  assign out_byte       = item_r.data;
  assign out_run_last   = item_r.last;
  assign out_local_echo = echo_r;

endmodule

// ===== sv/tnopt_checker.sv =====
// ---------------------------------------------------------------------------
// Telnet option parser port checker
// Watches the result channel of the parser unit for malformed result runs.
// ---------------------------------------------------------------------------
`include "telnet_option_parser_unit_defines.svh"

module tnopt_checker
  import tnopt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_local_echo
);

  logic        is_event, is_display, event_ok, mid_run, held;
  logic [10:0] out_word;

  assign is_event   = (out_kind == KIND_EVENT);
  assign is_display = (out_kind == KIND_DISPLAY);
  assign event_ok   = (out_byte == BYTE_ZERO) && out_run_last;
  assign mid_run    = out_valid && !out_stall && !out_run_last;
  assign held       = out_valid && out_stall;
  assign out_word   = {out_kind, out_byte, out_run_last};

  `TNOPT_ASSERT_NOW(a_event_last, out_valid && is_event, event_ok, "bad transfer event")
  `TNOPT_ASSERT_NOW(a_display_last, out_valid && is_display, out_run_last, "display not alone")
  `TNOPT_ASSERT_NEXT(a_run_continues, mid_run, out_valid && $stable(out_local_echo), "run broken")
  `TNOPT_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind telnet_option_parser_unit tnopt_checker u_tnopt_checker (.*);
